/* hdl/assert_macros.svh */
// Assertion macros shared by the tracker RTL.
// No dependencies; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, muted while reset is high.
`define FUST_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fust assertion failed");

// Check that a condition never holds outside reset.
`define FUST_NEVER(label, clk, rst, cond) \
  `FUST_ASSERT(label, clk, rst, !(cond))

`endif

/* hdl/fust_pkg.sv */
// Shared types and constants of the first-unique stream tracker.
// No dependencies; imported by fust_if, fust_ctrl, fust_dp, the top level and the bench.
package fust_pkg;

  localparam int VALUE_BITS = 10;
  localparam int NUM_VALUES = 1 << VALUE_BITS;
  localparam int LEVEL_BITS = 2;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [LEVEL_BITS-1:0] level_t;

  // Seen level of one value, saturating at repeated
  localparam level_t LVL_NEVER  = 2'd0;
  localparam level_t LVL_ONCE   = 2'd1;
  localparam level_t LVL_REPEAT = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;   // clear one seen-level entry
    logic accept;   // capture the incoming value, launch reads
    logic update;   // apply list update from read data
    logic emit;     // load the output register
  } fust_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last; // clear pointer on the last entry
    logic out_free; // output register empty or being drained
  } fust_sts_t;

endpackage

/* hdl/fust_if.sv */
// Valid/ready channel interfaces for the tracker input and result streams.
// Depends on fust_pkg.
interface fust_in_if import fust_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface fust_out_if import fust_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   has_unique;
  value_t first_unique;

  modport source (output valid, output has_unique, output first_unique, input ready);
  modport sink   (input valid, input has_unique, input first_unique, output ready);
endinterface

/* hdl/fust_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fust_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/fust_ctrl.sv */
// Sequencer of the tracker: clear sweep, accept, update, emit.
// Depends on fust_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fust_ctrl import fust_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  fust_sts_t sts,
  output fust_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_EMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR: if (sts.clr_last) state <= S_IDLE;
        S_IDLE:  if (in_valid)     state <= S_LOOK;
        S_LOOK:                    state <= S_EMIT;
        S_EMIT:  if (sts.out_free) state <= S_IDLE;
        default:                   state <= S_CLEAR;
      endcase
    end
  end

  always_comb begin
    in_ready   = (state == S_IDLE);
    cmd.clr_wr = (state == S_CLEAR);
    cmd.accept = (state == S_IDLE) && in_valid;
    cmd.update = (state == S_LOOK);
    cmd.emit   = (state == S_EMIT) && sts.out_free;
  end

  // An update always follows an accept
  `FUST_ASSERT(a_look_after_idle, clk, rst, (state == S_LOOK) |-> ($past(state) == S_IDLE))
  // The sweep ends in idle
  `FUST_ASSERT(a_clear_ends, clk, rst, ((state == S_CLEAR) && sts.clr_last) |=> (state == S_IDLE))

endmodule

/* hdl/fust_dp.sv */
// Datapath of the tracker: seen-level and link RAMs, list registers, result register.
// Depends on fust_pkg, fust_ram and assert_macros.svh.
`include "assert_macros.svh"

module fust_dp import fust_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  fust_cmd_t cmd,
  output fust_sts_t sts,
  input  value_t    value,
  output logic      out_valid,
  input  logic      out_ready,
  output logic      has_unique,
  output value_t    first_unique
);

  value_t cur_value;
  value_t list_head, list_head_next;
  value_t list_tail, list_tail_next;
  logic   list_empty, list_empty_next;
  value_t clr_addr;

  logic   seen_we;
  value_t seen_wa;
  level_t seen_wd;
  level_t seen_rd;
  logic   nx_we;
  value_t nx_wa, nx_wd, nx_rd;
  logic   pv_we;
  value_t pv_wa, pv_wd, pv_rd;

  fust_ram #(.WIDTH(LEVEL_BITS), .DEPTH(NUM_VALUES)) u_seen (
    .clk(clk), .wr_en(seen_we), .wr_addr(seen_wa), .wr_data(seen_wd),
    .rd_addr(value), .rd_data(seen_rd)
  );

  fust_ram #(.WIDTH(VALUE_BITS), .DEPTH(NUM_VALUES)) u_next (
    .clk(clk), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
    .rd_addr(value), .rd_data(nx_rd)
  );

  fust_ram #(.WIDTH(VALUE_BITS), .DEPTH(NUM_VALUES)) u_prev (
    .clk(clk), .wr_en(pv_we), .wr_addr(pv_wa), .wr_data(pv_wd),
    .rd_addr(value), .rd_data(pv_rd)
  );

  always_comb begin
    seen_we         = 1'b0;
    seen_wa         = cur_value;
    seen_wd         = LVL_NEVER;
    nx_we           = 1'b0;
    nx_wa           = list_tail;
    nx_wd           = cur_value;
    pv_we           = 1'b0;
    pv_wa           = cur_value;
    pv_wd           = list_tail;
    list_head_next  = list_head;
    list_tail_next  = list_tail;
    list_empty_next = list_empty;
    if (cmd.clr_wr) begin
      seen_we = 1'b1;
      seen_wa = clr_addr;
    end else if (cmd.update) begin
      unique case (seen_rd)
        LVL_NEVER: begin
          // First sighting: append at the tail
          seen_we = 1'b1;
          seen_wd = LVL_ONCE;
          if (list_empty) begin
            list_head_next  = cur_value;
            list_tail_next  = cur_value;
            list_empty_next = 1'b0;
          end else begin
            nx_we          = 1'b1;
            pv_we          = 1'b1;
            list_tail_next = cur_value;
          end
        end
        LVL_ONCE: begin
          // Second sighting: unlink
          seen_we = 1'b1;
          seen_wd = LVL_REPEAT;
          if (!list_empty) begin
            if (cur_value == list_head && cur_value == list_tail) begin
              list_empty_next = 1'b1;
              list_head_next  = '0;
              list_tail_next  = '0;
            end else if (cur_value == list_head) begin
              list_head_next = nx_rd;
            end else if (cur_value == list_tail) begin
              list_tail_next = pv_rd;
            end else begin
              nx_we = 1'b1;
              nx_wa = pv_rd;
              nx_wd = nx_rd;
              pv_we = 1'b1;
              pv_wa = nx_rd;
              pv_wd = pv_rd;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_value <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_head  <= '0;
      list_tail  <= '0;
      list_empty <= 1'b1;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.update) begin
        list_head  <= list_head_next;
        list_tail  <= list_tail_next;
        list_empty <= list_empty_next;
      end
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      has_unique   <= !list_empty;
      first_unique <= list_empty ? '0 : list_head;
    end
  end

  assign sts.clr_last = (clr_addr == value_t'(NUM_VALUES - 1));
  assign sts.out_free = !out_valid || out_ready;

  // An empty list keeps its pointers at zero
  `FUST_ASSERT(a_empty_ptrs, clk, rst, list_empty |-> (list_head == '0 && list_tail == '0))
  // An empty report always carries zero as first_unique
  `FUST_NEVER(a_emit_flag, clk, rst, out_valid && !has_unique && first_unique != '0)

endmodule

/* hdl/first_unique_stream_tracker_top.sv */
// Top level of the first-unique stream tracker.
// Depends on fust_pkg, fust_if, fust_ctrl and fust_dp.
//
//   channel  direction  payload                     handshake
//   in_ch    sink       value[9:0]                  valid/ready
//   out_ch   source     has_unique, first_unique    valid/ready
//
// Each transaction on in_ch yields exactly one transaction on out_ch.
// An item passes through accept (RAM reads launched), update (seen level
// and link writes, list pointers) and emit (load the output register);
// the RAM read data registered at accept feeds the update.
// After reset, a sweep clears the seen-level RAM one entry per cycle;
// in_ch.ready stays low until it finishes.
// A stalled output holds the block in emit; a new input transaction is
// taken while the previous result still waits in the output register.
module first_unique_stream_tracker_top import fust_pkg::*; (
  input logic       clk,
  input logic       rst,
  fust_in_if.sink   in_ch,
  fust_out_if.source out_ch
);

  fust_cmd_t cmd;
  fust_sts_t sts;

  // Sequence clear, accept, update and emit
  fust_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the seen levels, links, list pointers and the result register
  fust_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .value        (in_ch.value),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .has_unique   (out_ch.has_unique),
    .first_unique (out_ch.first_unique)
  );

endmodule

/* tb/testbench.sv */
// Self-checking bench for the first-unique stream tracker top level.
// Depends on fust_pkg, fust_if and first_unique_stream_tracker_top.
// A directed plan, then random first to third sightings, checked against an in-bench tracker.
module testbench import fust_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // One reported result: whether a unique value exists and the oldest one
  typedef struct packed {
    logic   has_unique;
    value_t first_unique;
  } unique_report_t;

  // Directed row: value to send, whether the result is typed in, and that result
  typedef struct packed {
    value_t         value;
    bit             typed;
    unique_report_t want;
  } plan_row_t;

  localparam int PLAN_ROWS    = 24;
  localparam int RANDOM_ITEMS = 1826;
  localparam int PHASE_ITEMS  = 150;

  // Typed rows walk the special cases: removing a lone entry, third
  // sightings, removal at head, middle and tail, and both extremes of value.
  // The untyped rows at the end rely on the tracker below.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{10'd0,    1'b1, '{1'b1, 10'd0}},
    '{10'd0,    1'b1, '{1'b0, 10'd0}},
    '{10'd0,    1'b1, '{1'b0, 10'd0}},
    '{10'd1023, 1'b1, '{1'b1, 10'd1023}},
    '{10'd5,    1'b1, '{1'b1, 10'd1023}},
    '{10'd1023, 1'b1, '{1'b1, 10'd5}},
    '{10'd7,    1'b1, '{1'b1, 10'd5}},
    '{10'd9,    1'b1, '{1'b1, 10'd5}},
    '{10'd7,    1'b1, '{1'b1, 10'd5}},
    '{10'd9,    1'b1, '{1'b1, 10'd5}},
    '{10'd1023, 1'b1, '{1'b1, 10'd5}},
    '{10'd5,    1'b1, '{1'b0, 10'd0}},
    '{10'd682,  1'b1, '{1'b1, 10'd682}},
    '{10'd341,  1'b1, '{1'b1, 10'd682}},
    '{10'd341,  1'b1, '{1'b1, 10'd682}},
    '{10'd682,  1'b1, '{1'b0, 10'd0}},
    '{10'd100,  1'b0, '{1'b0, 10'd0}},
    '{10'd200,  1'b0, '{1'b0, 10'd0}},
    '{10'd300,  1'b0, '{1'b0, 10'd0}},
    '{10'd200,  1'b0, '{1'b0, 10'd0}},
    '{10'd100,  1'b0, '{1'b0, 10'd0}},
    '{10'd512,  1'b0, '{1'b0, 10'd0}},
    '{10'd300,  1'b0, '{1'b0, 10'd0}},
    '{10'd512,  1'b0, '{1'b0, 10'd0}}
  };

  logic clk = 1'b0;
  logic rst;

  fust_in_if  in_ch ();
  fust_out_if out_ch ();

  first_unique_stream_tracker_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // In-bench tracker: seen level per value, links by value, list ends
  level_t sighting_lvl [NUM_VALUES];
  value_t later_link   [NUM_VALUES];
  value_t earlier_link [NUM_VALUES];
  value_t oldest_val;
  value_t newest_val;
  bit     none_unique;

  unique_report_t awaited_reports [$];
  int unsigned    mismatch_count = 0;
  int unsigned    pace;        // 0: no idling, 1: short gaps, 2: short and long gaps
  int unsigned    stall_left = 0;

  // Draw one gap length: mostly short, a few long, none at pace 0
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (pace == 0) return 0;
    roll = $urandom_range(99, 0);
    if (roll < 60) return 0;
    if (roll < 92 || pace == 1) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Apply one value to the tracker and return the report it causes
  function automatic unique_report_t track_value(value_t v);
    unique_report_t r;
    value_t p;
    value_t n;
    if (sighting_lvl[v] == LVL_NEVER) begin
      // First sighting: append at the tail
      sighting_lvl[v] = LVL_ONCE;
      if (none_unique) begin
        oldest_val  = v;
        newest_val  = v;
        none_unique = 1'b0;
      end else begin
        later_link[newest_val] = v;
        earlier_link[v]        = newest_val;
        newest_val             = v;
      end
    end else if (sighting_lvl[v] == LVL_ONCE) begin
      // Second sighting: unlink wherever it sits
      sighting_lvl[v] = LVL_REPEAT;
      p = earlier_link[v];
      n = later_link[v];
      if (v == oldest_val && v == newest_val) begin
        none_unique = 1'b1;
        oldest_val  = '0;
        newest_val  = '0;
      end else if (v == oldest_val) begin
        oldest_val = n;
      end else if (v == newest_val) begin
        newest_val = p;
      end else begin
        later_link[p]   = n;
        earlier_link[n] = p;
      end
    end
    r.has_unique   = !none_unique;
    r.first_unique = none_unique ? '0 : oldest_val;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Send one value: idle for a random gap, hold valid until the transaction
  // completes, then queue the expected report. Valid stays high across
  // back-to-back items so it never drops and rises in the same step.
  task automatic send_value(input value_t v, input bit typed, input unique_report_t want);
    int unsigned    gap;
    unique_report_t predicted;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= value_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    predicted = track_value(v);
    awaited_reports.insert(awaited_reports.size(), typed ? want : predicted);
  endtask

  // Hold the sender until every expected report has arrived
  task automatic drain_reports();
    in_ch.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls on ready
  always @(posedge clk) begin
    if (stall_left != 0) stall_left = stall_left - 1;
    else stall_left = pick_gap();
    out_ch.ready <= (stall_left == 0);
  end

  // Compare every result transaction with the oldest expectation
  always @(posedge clk) begin
    unique_report_t due;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (awaited_reports.size() == 0) begin
        flag_mismatch($sformatf("unexpected result has_unique=%0b first_unique=%0d",
                                out_ch.has_unique, out_ch.first_unique));
      end else begin
        due = awaited_reports.pop_front();
        if (out_ch.has_unique !== due.has_unique)
          flag_mismatch($sformatf("has_unique %0b, want %0b",
                                  out_ch.has_unique, due.has_unique));
        if (out_ch.first_unique !== due.first_unique)
          flag_mismatch($sformatf("first_unique %0d, want %0d",
                                  out_ch.first_unique, due.first_unique));
      end
    end
  end

  // Stimulus
  initial begin
    value_t      fresh_vals [$];
    value_t      once_vals [$];
    value_t      repeat_vals [$];
    value_t      pick;
    value_t      swap_tmp;
    int unsigned sent;
    int unsigned remove_pct;
    int unsigned roll;
    int unsigned idx;
    int unsigned j;

    for (int v = 0; v < NUM_VALUES; v++) begin
      sighting_lvl[v] = LVL_NEVER;
      later_link[v]   = '0;
      earlier_link[v] = '0;
    end
    oldest_val     = '0;
    newest_val     = '0;
    none_unique    = 1'b1;
    pace           = 1;

    rst          <= 1'b1;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed plan; the first handshake waits out the clearing sweep
    for (int i = 0; i < PLAN_ROWS; i++)
      send_value(PLAN[i].value, PLAN[i].typed, PLAN[i].want);
    drain_reports();

    // Sort values by what the plan left behind; shuffle the unseen ones
    for (int v = 0; v < NUM_VALUES; v++) begin
      if (sighting_lvl[v] == LVL_NEVER) fresh_vals.insert(fresh_vals.size(), value_t'(v));
      else if (sighting_lvl[v] == LVL_ONCE) once_vals.insert(once_vals.size(), value_t'(v));
      else repeat_vals.insert(repeat_vals.size(), value_t'(v));
    end
    for (int i = fresh_vals.size() - 1; i > 0; i--) begin
      j             = $urandom_range(i, 0);
      swap_tmp      = fresh_vals[i];
      fresh_vals[i] = fresh_vals[j];
      fresh_vals[j] = swap_tmp;
    end

    // Random part: phases with their own removal rate and idling pace.
    // Most items are first or second sightings; a few are third sightings.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      remove_pct = $urandom_range(65, 30);
      pace       = $urandom_range(2, 0);
      for (int k = 0; k < PHASE_ITEMS && sent < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(99, 0);
        if (roll < 5 && repeat_vals.size() != 0) begin
          pick = repeat_vals[$urandom_range(repeat_vals.size() - 1, 0)];
        end else if (once_vals.size() != 0 &&
                     (roll < remove_pct || fresh_vals.size() == 0)) begin
          // Bias removals toward the head and tail of the list
          roll = $urandom_range(99, 0);
          if (roll < 30) idx = 0;
          else if (roll < 50) idx = once_vals.size() - 1;
          else idx = $urandom_range(once_vals.size() - 1, 0);
          pick = once_vals[idx];
          once_vals.delete(idx);
          repeat_vals.insert(repeat_vals.size(), pick);
        end else if (fresh_vals.size() != 0) begin
          pick = fresh_vals.pop_front();
          once_vals.insert(once_vals.size(), pick);
        end else begin
          pick = value_t'($urandom);
        end
        send_value(pick, 1'b0, '0);
        sent++;
      end
      if ($urandom_range(2, 0) == 0) drain_reports();
    end

    // Wind down: drop valid, wait for every report, then allow stray results
    in_ch.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
